### hdl/dmps_pkg.sv
// Shared types, constants and codes for the dedup min-priority set.
package dmps_pkg;

    localparam int CAPACITY  = 64;
    localparam int ID_BITS   = 12;
    localparam int DIST_BITS = 16;
    localparam int STATUS_W  = 3;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic shift_init;
        logic shift_rd;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic iss_done;
        logic pipe_busy;
        logic is_pop;
        logic have_best;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/dmps_if.sv
// Request and result channel interfaces.
interface dmps_req_if #(
    parameter int ID_BITS   = dmps_pkg::ID_BITS,
    parameter int DIST_BITS = dmps_pkg::DIST_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [ID_BITS-1:0]   node_id;
    logic [DIST_BITS-1:0] node_distance;

    modport source (output valid, opcode, node_id, node_distance, input ready);
    modport sink   (input valid, opcode, node_id, node_distance, output ready);
endinterface

interface dmps_res_if #(
    parameter int ID_BITS   = dmps_pkg::ID_BITS,
    parameter int DIST_BITS = dmps_pkg::DIST_BITS,
    parameter int CNT_W     = $clog2(dmps_pkg::CAPACITY + 1)
);
    logic                          valid;
    logic                          ready;
    logic [ID_BITS-1:0]            popped_id;
    logic [DIST_BITS-1:0]          popped_distance;
    logic [dmps_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]              member_count;

    modport source (output valid, popped_id, popped_distance, status, member_count,
                    input ready);
    modport sink   (input valid, popped_id, popped_distance, status, member_count,
                    output ready);
endinterface

### hdl/dmps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/dmps_ctrl.sv
// Controller: sequences the scan, compaction and result phases of one item.
module dmps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  dmps_pkg::t_dp_sts i_sts,
    output dmps_pkg::t_dp_cmd o_cmd
);
    dmps_pkg::t_state r_state;
    dmps_pkg::t_state n_state;
    logic             w_drained;

    assign w_drained = i_sts.iss_done && !i_sts.pipe_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmps_pkg::S_IDLE: begin
                if (i_req_valid) n_state = dmps_pkg::S_SCAN;
            end
            dmps_pkg::S_SCAN: begin
                if (w_drained) begin
                    n_state = (i_sts.is_pop && i_sts.have_best) ? dmps_pkg::S_SHIFT
                                                                : dmps_pkg::S_DONE;
                end
            end
            dmps_pkg::S_SHIFT: begin
                if (w_drained) n_state = dmps_pkg::S_DONE;
            end
            dmps_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = dmps_pkg::S_IDLE;
            end
            default: n_state = dmps_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready      = (r_state == dmps_pkg::S_IDLE);
        o_cmd            = '0;
        o_cmd.load       = (r_state == dmps_pkg::S_IDLE) && i_req_valid;
        o_cmd.scan_rd    = (r_state == dmps_pkg::S_SCAN) && !i_sts.iss_done;
        o_cmd.shift_init = (r_state == dmps_pkg::S_SCAN) && w_drained &&
                           i_sts.is_pop && i_sts.have_best;
        o_cmd.shift_rd   = (r_state == dmps_pkg::S_SHIFT) && !i_sts.iss_done;
        o_cmd.fin        = (r_state == dmps_pkg::S_DONE) && i_sts.out_free;
    end
endmodule

### hdl/dmps_dp.sv
// Datapath: entry memory, scan compare, compaction and result register.
module dmps_dp #(
    parameter int CAPACITY  = dmps_pkg::CAPACITY,
    parameter int ID_BITS   = dmps_pkg::ID_BITS,
    parameter int DIST_BITS = dmps_pkg::DIST_BITS,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmps_pkg::t_dp_cmd             i_cmd,
    output dmps_pkg::t_dp_sts             o_sts,
    input  logic                          i_opcode,
    input  logic [ID_BITS-1:0]            i_node_id,
    input  logic [DIST_BITS-1:0]          i_node_distance,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [ID_BITS-1:0]            o_popped_id,
    output logic [DIST_BITS-1:0]          o_popped_distance,
    output logic [dmps_pkg::STATUS_W-1:0] o_status,
    output logic [CNT_W-1:0]              o_member_count
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int WORD_W = ID_BITS + DIST_BITS;

    logic [CNT_W-1:0]     r_count;
    logic                 r_op;
    logic [ID_BITS-1:0]   r_id;
    logic [DIST_BITS-1:0] r_dist;
    logic [CNT_W-1:0]     r_iss;
    logic                 r_shift_mode;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_have_best;
    logic [IDX_W-1:0]     r_best_idx;
    logic [ID_BITS-1:0]   r_best_node;
    logic [DIST_BITS-1:0] r_best_key;

    logic                          r_out_vld;
    logic [ID_BITS-1:0]            r_out_id;
    logic [DIST_BITS-1:0]          r_out_dist;
    logic [dmps_pkg::STATUS_W-1:0] r_out_st;
    logic [CNT_W-1:0]              r_out_cnt;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [WORD_W-1:0]    w_wdata;
    logic [WORD_W-1:0]    w_rdata;
    logic [ID_BITS-1:0]   w_rd_node;
    logic [DIST_BITS-1:0] w_rd_key;
    logic                 w_full;
    logic                 w_out_free;
    logic                 w_shift_wr;
    logic                 w_push_wr;

    assign w_rd_node  = w_rdata[WORD_W-1 -: ID_BITS];
    assign w_rd_key   = w_rdata[DIST_BITS-1:0];
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_shift_wr = r_cmp_vld && r_shift_mode;
    assign w_push_wr  = i_cmd.fin && (r_op == dmps_pkg::OP_PUSH) && (r_hit || !w_full);

    always_comb begin
        w_we    = w_shift_wr || w_push_wr;
        w_waddr = r_cmp_idx - IDX_W'(1);
        w_wdata = w_rdata;
        if (!w_shift_wr) begin
            w_waddr = r_hit ? r_hit_idx : r_count[IDX_W-1:0];
            w_wdata = {r_id, r_dist};
        end
    end

    dmps_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_iss[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd || i_cmd.shift_rd;
            if (i_cmd.fin) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.fin) begin
                if (r_op == dmps_pkg::OP_PUSH) begin
                    if (!r_hit && !w_full) r_count <= r_count + CNT_W'(1);
                end else if (r_have_best) begin
                    r_count <= r_count - CNT_W'(1);
                end
            end
        end
    end

    // item and scan payload
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_iss[IDX_W-1:0];
        if (i_cmd.load) begin
            r_op         <= i_opcode;
            r_id         <= i_node_id;
            r_dist       <= i_node_distance;
            r_iss        <= '0;
            r_shift_mode <= 1'b0;
            r_hit        <= 1'b0;
            r_have_best  <= 1'b0;
        end else if (i_cmd.shift_init) begin
            r_iss        <= CNT_W'(r_best_idx) + CNT_W'(1);
            r_shift_mode <= 1'b1;
        end else if (i_cmd.scan_rd || i_cmd.shift_rd) begin
            r_iss <= r_iss + CNT_W'(1);
        end
        if (r_cmp_vld && !r_shift_mode) begin
            if (r_op == dmps_pkg::OP_PUSH) begin
                if (w_rd_node == r_id) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                end
            end else if (!r_have_best || w_rd_key <= r_best_key) begin
                // ascending scan with <= keeps the newest of tied minima
                r_have_best <= 1'b1;
                r_best_idx  <= r_cmp_idx;
                r_best_node <= w_rd_node;
                r_best_key  <= w_rd_key;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_id   <= '0;
            r_out_dist <= '0;
            if (r_op == dmps_pkg::OP_PUSH) begin
                r_out_cnt <= (!r_hit && !w_full) ? r_count + CNT_W'(1) : r_count;
                if (r_hit) begin
                    r_out_st <= dmps_pkg::ST_PRESENT;
                end else if (w_full) begin
                    r_out_st <= dmps_pkg::ST_FULL;
                end else begin
                    r_out_st <= dmps_pkg::ST_INSERTED;
                end
            end else if (r_have_best) begin
                r_out_id   <= r_best_node;
                r_out_dist <= r_best_key;
                r_out_st   <= dmps_pkg::ST_POPPED;
                r_out_cnt  <= r_count - CNT_W'(1);
            end else begin
                r_out_st  <= dmps_pkg::ST_EMPTY;
                r_out_cnt <= r_count;
            end
        end
    end

    always_comb begin
        o_sts.iss_done  = (r_iss == r_count);
        o_sts.pipe_busy = r_cmp_vld;
        o_sts.is_pop    = (r_op == dmps_pkg::OP_POP);
        o_sts.have_best = r_have_best;
        o_sts.out_free  = w_out_free;
    end

    assign o_out_valid       = r_out_vld;
    assign o_popped_id       = r_out_id;
    assign o_popped_distance = r_out_dist;
    assign o_status          = r_out_st;
    assign o_member_count    = r_out_cnt;
endmodule

### hdl/dedup_min_priority_set.sv
// Each item reads every member once, one entry per cycle through the registered read of the
// entry RAM, and compares it before the result register is loaded; a pop then compacts the
// entries above the removed one (none when the newest member goes). One item is in work at
// a time.
// Sync active-low reset clears count and control state; entry RAM is not cleared.
module dedup_min_priority_set #(
    parameter int CAPACITY  = dmps_pkg::CAPACITY,
    parameter int ID_BITS   = dmps_pkg::ID_BITS,
    parameter int DIST_BITS = dmps_pkg::DIST_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmps_req_if.sink   i_req,
    dmps_res_if.source o_res
);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    dmps_pkg::t_dp_cmd w_cmd;
    dmps_pkg::t_dp_sts w_sts;

    dmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dmps_dp #(
        .CAPACITY  (CAPACITY),
        .ID_BITS   (ID_BITS),
        .DIST_BITS (DIST_BITS),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_opcode          (i_req.opcode),
        .i_node_id         (i_req.node_id),
        .i_node_distance   (i_req.node_distance),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_popped_id       (o_res.popped_id),
        .o_popped_distance (o_res.popped_distance),
        .o_status          (o_res.status),
        .o_member_count    (o_res.member_count)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.member_count <= CNT_W'(CAPACITY)))
        else $error("member count above capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == dmps_pkg::ST_EMPTY) |->
        (o_res.member_count == '0 && o_res.popped_id == '0 && o_res.popped_distance == '0))
        else $error("empty pop with nonzero fields");

    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.fin |-> (!w_sts.pipe_busy && w_sts.iss_done))
        else $error("result issued with scan still running");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !(w_cmd.scan_rd || w_cmd.shift_rd || w_cmd.fin || w_cmd.shift_init))
        else $error("item accepted while another is in work");
`endif
endmodule

### verif/dedup_min_priority_set_tb.sv
// Self-checking testbench for the dedup min-priority set: directed, fill and random tests.
module dedup_min_priority_set_tb;

    localparam int CNT_W        = $clog2(dmps_pkg::CAPACITY + 1);
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 2 * dmps_pkg::CAPACITY + 10;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_GAP      = 17;

    typedef struct packed {
        logic [dmps_pkg::ID_BITS-1:0]   id;
        logic [dmps_pkg::DIST_BITS-1:0] distance;
        dmps_pkg::t_status              status;
        logic [CNT_W-1:0]               members;
    } t_frontier_result;

    logic i_clk;
    logic i_rst_n;

    dmps_req_if req_if ();
    dmps_res_if res_if ();

    dedup_min_priority_set dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Shadow copy of the frontier, members in insertion order
    logic [dmps_pkg::ID_BITS-1:0]   frontier_node [dmps_pkg::CAPACITY];
    logic [dmps_pkg::DIST_BITS-1:0] frontier_key  [dmps_pkg::CAPACITY];
    int                             frontier_count;

    t_frontier_result pending_results[$];
    int               mismatch_count;
    bit               sender_no_gap;
    bit               sink_no_stall;
    int               sink_hold_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_frontier_result predict_frontier(
        logic op, logic [dmps_pkg::ID_BITS-1:0] id, logic [dmps_pkg::DIST_BITS-1:0] node_dist);
        t_frontier_result r;
        bit               found;
        int               best;
        r     = '0;
        found = 1'b0;
        if (op == dmps_pkg::OP_PUSH) begin
            // duplicate check comes before the fullness check
            for (int i = 0; i < frontier_count; i++) begin
                if (!found && frontier_node[i] == id) begin
                    frontier_key[i] = node_dist;
                    found           = 1'b1;
                end
            end
            if (found) begin
                r.status = dmps_pkg::ST_PRESENT;
            end else if (frontier_count >= dmps_pkg::CAPACITY) begin
                r.status = dmps_pkg::ST_FULL;
            end else begin
                frontier_node[frontier_count] = id;
                frontier_key[frontier_count]  = node_dist;
                frontier_count++;
                r.status = dmps_pkg::ST_INSERTED;
            end
        end else if (frontier_count == 0) begin
            r.status = dmps_pkg::ST_EMPTY;
        end else begin
            // scan from the newest down; strict less-than keeps the newest on a tie
            best = frontier_count - 1;
            for (int i = frontier_count - 2; i >= 0; i--) begin
                if (frontier_key[i] < frontier_key[best]) best = i;
            end
            r.id       = frontier_node[best];
            r.distance = frontier_key[best];
            for (int i = best; i < frontier_count - 1; i++) begin
                frontier_node[i] = frontier_node[i+1];
                frontier_key[i]  = frontier_key[i+1];
            end
            frontier_count--;
            r.status = dmps_pkg::ST_POPPED;
        end
        r.members = CNT_W'(frontier_count);
        return r;
    endfunction

    // Offer one beat after a random gap (none when sender_no_gap is set); returns at the edge that accepts it.
    task automatic send_item(logic op, logic [dmps_pkg::ID_BITS-1:0] id,
                             logic [dmps_pkg::DIST_BITS-1:0] node_dist);
        int gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.node_id       <= id;
        req_if.node_distance <= node_dist;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        pending_results.push_back(predict_frontier(op, id, node_dist));
    endtask

    task automatic send_pop();
        send_item(dmps_pkg::OP_POP, dmps_pkg::ID_BITS'($urandom),
                  dmps_pkg::DIST_BITS'($urandom));
    endtask

    task automatic wait_all_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, duplicates, ties, empty pops
    task automatic test_directed_edges();
        send_pop();
        send_item(dmps_pkg::OP_PUSH, '0, '0);
        send_item(dmps_pkg::OP_PUSH, '1, '1);
        send_item(dmps_pkg::OP_PUSH, '0, '1);  // refresh in place, now tied with the newer one
        send_pop();
        send_pop();
        send_pop();
        send_item(dmps_pkg::OP_PUSH, 12'd10, 16'd5);
        send_item(dmps_pkg::OP_PUSH, 12'd20, 16'd5);
        send_item(dmps_pkg::OP_PUSH, 12'd30, 16'd5);
        send_item(dmps_pkg::OP_PUSH, 12'd40, 16'd3);
        repeat (4) send_pop();
        send_item(dmps_pkg::OP_PUSH, 12'hAAA, 16'hAAAA);
        send_item(dmps_pkg::OP_PUSH, 12'h555, 16'h5555);
        send_item(dmps_pkg::OP_PUSH, 12'h555, 16'hFFFF);
        send_pop();
        send_pop();
        send_pop();
        wait_all_results();
    endtask

    // Fill past capacity while the result side holds off for a long stretch
    task automatic test_fill_under_backpressure();
        for (int n = 0; n < 76; n++) begin
            if (n == 8) sink_hold_cycles = LONG_HOLD;
            if (frontier_count == dmps_pkg::CAPACITY && n[0])
                send_item(dmps_pkg::OP_PUSH,
                          frontier_node[$urandom_range(0, dmps_pkg::CAPACITY - 1)],
                          dmps_pkg::DIST_BITS'($urandom));
            else
                send_item(dmps_pkg::OP_PUSH, dmps_pkg::ID_BITS'($urandom),
                          dmps_pkg::DIST_BITS'($urandom));
        end
        // sender pauses until the block has answered everything
        wait_all_results();
    endtask

    task automatic test_random_frontier();
        int push_pct;
        int id_span;
        int dist_span;
        logic op;
        for (int blk = 0; blk < 18; blk++) begin
            push_pct      = $urandom_range(20, 85);
            id_span       = $urandom_range(0, 1) ? $urandom_range(7, 127)
                                                 : (1 << dmps_pkg::ID_BITS) - 1;
            dist_span     = $urandom_range(0, 2) == 0 ? 3 : (1 << dmps_pkg::DIST_BITS) - 1;
            sender_no_gap = (blk % 5 == 1) || (blk % 5 == 3);
            sink_no_stall = (blk % 5 == 1) || (blk % 5 == 4);
            for (int n = 0; n < 50; n++) begin
                op = ($urandom_range(0, 99) < push_pct) ? dmps_pkg::OP_PUSH : dmps_pkg::OP_POP;
                if (op == dmps_pkg::OP_PUSH)
                    send_item(dmps_pkg::OP_PUSH, dmps_pkg::ID_BITS'($urandom_range(0, id_span)),
                              dmps_pkg::DIST_BITS'($urandom_range(0, dist_span)));
                else
                    send_pop();
            end
            if (blk % 6 == 5) wait_all_results();
        end
        sender_no_gap = 1'b0;
        sink_no_stall = 1'b0;
    endtask

    task automatic test_final_drain();
        while (frontier_count > 0) send_pop();
        send_pop();
    endtask

    initial begin : result_sink
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                res_if.ready <= 1'b0;
            end else if (res_if.valid && res_if.ready) begin
                stall = sink_no_stall ? 0 : $urandom_range(0, MAX_GAP);
                res_if.ready <= (stall == 0);
            end else if (stall > 0) begin
                stall--;
                res_if.ready <= (stall == 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_frontier_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d", res_if.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_if.popped_id !== want.id) begin
                    $error("popped_id: expected %0d, actual %0d", want.id, res_if.popped_id);
                    mismatch_count++;
                end
                if (res_if.popped_distance !== want.distance) begin
                    $error("popped_distance: expected %0d, actual %0d",
                           want.distance, res_if.popped_distance);
                    mismatch_count++;
                end
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_if.status);
                    mismatch_count++;
                end
                if (res_if.member_count !== want.members) begin
                    $error("member_count: expected %0d, actual %0d",
                           want.members, res_if.member_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
                idle = 0;
            end else begin
                idle++;
                if (idle >= IDLE_LIMIT) begin
                    $display("dedup_min_priority_set test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        mismatch_count       = 0;
        frontier_count       = 0;
        sender_no_gap        = 1'b0;
        sink_no_stall        = 1'b0;
        sink_hold_cycles     = 0;
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.opcode        <= dmps_pkg::OP_PUSH;
        req_if.node_id       <= '0;
        req_if.node_distance <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_fill_under_backpressure();
        test_random_frontier();
        test_final_drain();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("dedup_min_priority_set test passed");
        end else begin
            $display("dedup_min_priority_set test failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/dmps_pkg.sv
hdl/dmps_if.sv
hdl/dmps_ram.sv
hdl/dmps_ctrl.sv
hdl/dmps_dp.sv
hdl/dedup_min_priority_set.sv
verif/dedup_min_priority_set_tb.sv
